>>> hw/rtl/double_ended_queue_defines.svh
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DEQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> hw/rtl/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int IO_BITS   = 32;
  localparam int OCC_BITS  = 5;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  function automatic word_t in_to_word(logic [IO_BITS-1:0] v);
    logic [63:0] wide;
    wide = {32'd0, v};
    return wide[WORD_BITS-1:0];
  endfunction

  function automatic logic [IO_BITS-1:0] word_to_out(word_t w);
    logic [63:0] wide;
    wide = 64'(w);
    return wide[IO_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/deq_ram.sv
module deq_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int ADDR_P  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_P-1:0]  waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_P-1:0]  raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/double_ended_queue.sv
// pushes, errors and unused kinds: result strobe in the cycle after acceptance
// pops and peeks: the registered store read is followed by ST_READ, which registers the result and strobe
// throughput: one push per cycle while not busy; a pop or peek holds busy in ST_READ until its result is registered
// synchronous reset returns state to idle and clears front index, count and strobe; store contents are kept
// results are never held back: the receiver cannot stall
`include "double_ended_queue_defines.svh"

module double_ended_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    kind,
  input  logic signed [31:0]            value,
  output logic                          done,
  output logic signed [31:0]            result_value,
  output logic [1:0]                    status,
  output logic [4:0]                    occupancy
);

  import deq_pkg::*;

  state_t state, state_next;
  idx_t   front, front_next;
  cnt_t   count, count_next;
  logic   done_next;
  logic [IO_BITS-1:0] res_reg;
  status_t stat_reg, stat_next;
  logic [OCC_BITS-1:0] occ_reg;

  logic  accept;
  logic  full, empty;
  idx_t  front_dec, front_inc, back_slot, push_slot;
  logic [CNT_BITS:0] back_raw, push_raw;

  logic  we, re;
  idx_t  waddr, raddr;
  word_t rdata;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_READ);
  assign full   = (count >= cnt_t'(DEPTH));
  assign empty  = (count == '0);

  assign front_dec = (front == '0) ? idx_t'(DEPTH - 1) : front - idx_t'(1);
  assign front_inc = (front == idx_t'(DEPTH - 1)) ? '0 : front + idx_t'(1);

  assign back_raw  = (CNT_BITS+1)'(front) + (CNT_BITS+1)'(count) - (CNT_BITS+1)'(1);
  assign push_raw  = (CNT_BITS+1)'(front) + (CNT_BITS+1)'(count);
  assign back_slot = (back_raw >= (CNT_BITS+1)'(DEPTH)) ?
                     idx_t'(back_raw - (CNT_BITS+1)'(DEPTH)) : idx_t'(back_raw);
  assign push_slot = (push_raw >= (CNT_BITS+1)'(DEPTH)) ?
                     idx_t'(push_raw - (CNT_BITS+1)'(DEPTH)) : idx_t'(push_raw);

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    stat_next  = STAT_OK;
    done_next  = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = front;
    raddr      = front;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          unique case (kind)
            KIND_PUSH_FRONT: begin
              if (full) begin
                stat_next = STAT_FULL;
              end else begin
                we         = 1'b1;
                waddr      = front_dec;
                front_next = front_dec;
                count_next = count + cnt_t'(1);
              end
            end
            KIND_PUSH_BACK: begin
              if (full) begin
                stat_next = STAT_FULL;
              end else begin
                we         = 1'b1;
                waddr      = push_slot;
                count_next = count + cnt_t'(1);
              end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT: begin
              if (empty) begin
                stat_next = STAT_EMPTY;
              end else begin
                re         = 1'b1;
                raddr      = front;
                done_next  = 1'b0;
                state_next = ST_READ;
                if (kind == KIND_POP_FRONT) begin
                  front_next = front_inc;
                  count_next = count - cnt_t'(1);
                end
              end
            end
            KIND_POP_BACK, KIND_PEEK_BACK: begin
              if (empty) begin
                stat_next = STAT_EMPTY;
              end else begin
                re         = 1'b1;
                raddr      = back_slot;
                done_next  = 1'b0;
                state_next = ST_READ;
                if (kind == KIND_POP_BACK) begin
                  count_next = count - cnt_t'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_reg  <= '0;
      stat_reg <= stat_next;
      occ_reg  <= OCC_BITS'(count_next);
    end else if (state == ST_READ) begin
      res_reg <= word_to_out(rdata);
    end
  end

  deq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_BITS),
    .ADDR_P  (IDX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we && accept),
    .waddr (waddr),
    .wdata (in_to_word(value)),
    .re    (re && accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign result_value = $signed(res_reg);
  assign status       = stat_reg;
  assign occupancy    = occ_reg;

  `DEQ_ASSERT_NEVER(a_count_range, count > cnt_t'(DEPTH), "count beyond depth")
  `DEQ_ASSERT_NEVER(a_front_range, front > idx_t'(DEPTH - 1), "front index out of range")
  `DEQ_ASSERT(a_read_done, busy |=> done && !busy, "store read without result")
  `DEQ_ASSERT(a_full_occ, done && stat_reg == STAT_FULL |-> occ_reg == OCC_BITS'(DEPTH), "full with room left")
  `DEQ_ASSERT(a_empty_occ, done && stat_reg == STAT_EMPTY |-> occ_reg == '0 && res_reg == '0, "empty result not clean")

endmodule
